FILE: hdl/qra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qra_pkg
// Shared widths, register codes, controller states and the command and
// status bundles of the queue reward accumulator.
// ----------------------------------------------------------------------------
package qra_pkg;

  // input item fields
  localparam int Q_W         = 8;
  localparam int P_W         = 32;
  localparam int IN_DATA_W   = 40;

  // buffer size that marks a full (loss) state
  localparam int BUFFER_SIZE = 64;

  // default server count, handed down from the top level
  localparam int SERVERS_DEFAULT = 4;

  // configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int THRESH_W    = 40;
  localparam int RATE_W      = 16;
  localparam int LEVELS      = 6;
  localparam int LEVEL_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1    = 3'd2;

  // accumulators and results
  localparam int QSUM_W     = 40;
  localparam int LOSS_W     = 32;
  localparam int ENERGY_W   = 48;
  localparam int MEANQ_W    = 39;
  localparam int RT_W       = 48;
  localparam int OUT_DATA_W = 168;

  localparam logic [QSUM_W-1:0] QSUM_MAX = 40'd255 << 31;
  localparam logic [LOSS_W-1:0] LOSS_ONE = 32'h8000_0000;

  // response time division: (queue_sum << 16) / (rate * (1 - loss))
  localparam int FRAC_W    = 16;
  localparam int DEN_W     = RATE_W + LOSS_W;
  localparam int DIVD_W    = QSUM_W + FRAC_W;
  localparam int DIV_STEPS = DIVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // controller states
  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_MULT,
    ST_DIVIDE,
    ST_PUBLISH
  } qra_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic mult;
    logic div_step;
    logic publish;
  } qra_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_xfer;
    logic pipe_empty;
    logic div_last;
    logic out_free;
  } qra_status_t;

endpackage

FILE: hdl/qra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qra_ctrl
// Frame sequencer: accumulate, drain the product pipeline, form the
// divisor, divide, then hand the result to the output register.
// ----------------------------------------------------------------------------
module qra_ctrl
  import qra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  qra_status_t status,
  output qra_cmd_t    cmd
);

  qra_state_t state;
  qra_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_ACCUM: begin
        if (status.last_xfer) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.pipe_empty) state_next = ST_MULT;
      end
      ST_MULT: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_last) state_next = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (status.out_free) state_next = ST_ACCUM;
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    case (state)
      ST_ACCUM:   cmd.accept   = 1'b1;
      ST_DRAIN:   cmd.load     = status.pipe_empty;
      ST_MULT:    cmd.mult     = 1'b1;
      ST_DIVIDE:  cmd.div_step = 1'b1;
      ST_PUBLISH: cmd.publish  = status.out_free;
      default:    cmd          = '0;
    endcase
  end

endmodule

FILE: hdl/qra_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qra_datapath
// Configuration registers, three-stage reward pipeline with saturating
// accumulators, bit-serial response-time divider and output register.
// ----------------------------------------------------------------------------
module qra_datapath
  import qra_pkg::*;
#(
  parameter int SERVERS = SERVERS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  m_tready,
  input  qra_cmd_t              cmd,
  output qra_status_t           status,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser
);

  localparam int BUSY_W  = $clog2(SERVERS + 1);
  localparam int POWER_W = BUSY_W + 32;
  localparam int HALF_W  = 16;
  localparam int PROD_W  = POWER_W + HALF_W;
  localparam int TERM_W  = POWER_W + 2;
  localparam logic [Q_W-1:0]    SERVERS_Q = Q_W'(SERVERS);
  localparam logic [BUSY_W-1:0] SERVERS_B = BUSY_W'(SERVERS);
  localparam logic [Q_W-1:0]    FULL_Q    = Q_W'(BUFFER_SIZE);

  logic in_xfer;

  // configuration registers
  logic [THRESH_W-1:0]   threshold_pack;
  logic [RATE_W-1:0]     arrival_rate;
  logic [CFG_DATA_W-1:0] level_power [LEVELS];

  // pipeline registers
  logic               s1_valid;
  logic [Q_W-1:0]     s1_q;
  logic [P_W-1:0]     s1_p;
  logic               s2_valid;
  logic [POWER_W-1:0] s2_power;
  logic [QSUM_W-1:0]  s2_qp;
  logic [P_W-1:0]     s2_p;
  logic               s2_full;
  logic               s3_valid;
  logic [PROD_W-1:0]  s3_hi;
  logic [PROD_W-1:0]  s3_lo;
  logic [QSUM_W-1:0]  s3_qp;
  logic [P_W-1:0]     s3_p;
  logic               s3_full;

  // stage one logic
  logic [LEVEL_IDX_W-1:0] level;
  logic [CFG_DATA_W-1:0]  sel_power;
  logic [BUSY_W-1:0]      busy;
  logic [BUSY_W-1:0]      idle;
  logic [POWER_W-1:0]     power_next;

  // stage three logic
  logic [PROD_W:0]     term_sum;
  logic [TERM_W-1:0]   term;
  logic [QSUM_W:0]     q_add;
  logic [LOSS_W:0]     loss_add;
  logic [ENERGY_W:0]   e_add;

  // accumulators
  logic [QSUM_W-1:0]   queue_sum;
  logic [LOSS_W-1:0]   loss_sum;
  logic [ENERGY_W-1:0] energy_sum;
  logic [QSUM_W-1:0]   queue_sum_next;
  logic [LOSS_W-1:0]   loss_sum_next;
  logic [ENERGY_W-1:0] energy_sum_next;

  // frame snapshot and divider
  logic [QSUM_W-1:0]   snap_qsum;
  logic [LOSS_W-1:0]   snap_loss;
  logic [ENERGY_W-1:0] snap_energy;
  logic [DEN_W-1:0]    denom;
  logic [DEN_W-1:0]    rem;
  logic [DIVD_W-1:0]   quo;
  logic [STEP_W-1:0]   step;
  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      rem_diff;
  logic                fits;
  logic                dz;
  logic [RT_W-1:0]     rt;

  // output register
  logic [MEANQ_W-1:0]  out_mean;
  logic [LOSS_W-1:0]   out_loss;
  logic [ENERGY_W-1:0] out_energy;
  logic [RT_W-1:0]     out_rt;
  logic                out_dz;

  assign in_xfer = s_tvalid && cmd.accept;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_pack <= '0;
      arrival_rate   <= RATE_W'(1);
      for (int k = 0; k < LEVELS; k++) begin
        level_power[k] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold_pack <= cfg_data[THRESH_W-1:0];
        CFG_RATE:      arrival_rate   <= cfg_data[RATE_W-1:0];
        default:       level_power[LEVEL_IDX_W'(cfg_index - CFG_LEVEL1)] <= cfg_data;
      endcase
    end
  end

  // stage one: capture the item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_xfer;
    end
    if (in_xfer) begin
      s1_q <= s_tdata[Q_W-1:0];
      s1_p <= s_tdata[Q_W +: P_W];
    end
  end

  // level choice, first threshold at or above the queue length wins
  always_comb begin
    level = LEVEL_IDX_W'(LEVELS - 1);
    for (int k = LEVELS - 2; k >= 0; k--) begin
      if (s1_q <= threshold_pack[8*k +: 8]) level = LEVEL_IDX_W'(k);
    end
  end

  // server split and state power
  always_comb begin
    sel_power  = level_power[level];
    busy       = (s1_q < SERVERS_Q) ? BUSY_W'(s1_q) : SERVERS_B;
    idle       = SERVERS_B - busy;
    power_next = POWER_W'(busy) * POWER_W'(sel_power[63:32])
               + POWER_W'(idle) * POWER_W'(sel_power[31:0]);
  end

  // stage two: power, queue product, full flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_power <= power_next;
    s2_qp    <= QSUM_W'(s1_q) * QSUM_W'(s1_p);
    s2_p     <= s1_p;
    s2_full  <= (s1_q == FULL_Q);
  end

  // stage three: power times probability as two half products
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_hi   <= PROD_W'(s2_power) * PROD_W'(s2_p[P_W-1:HALF_W]);
    s3_lo   <= PROD_W'(s2_power) * PROD_W'(s2_p[HALF_W-1:0]);
    s3_qp   <= s2_qp;
    s3_p    <= s2_p;
    s3_full <= s2_full;
  end

  // energy term and saturating sums
  always_comb begin
    term_sum = (PROD_W + 1)'(s3_hi) + (PROD_W + 1)'(s3_lo >> HALF_W);
    term     = TERM_W'(term_sum >> 15);

    q_add = {1'b0, queue_sum} + {1'b0, s3_qp};
    queue_sum_next = (q_add > {1'b0, QSUM_MAX}) ? QSUM_MAX : q_add[QSUM_W-1:0];

    loss_add = {1'b0, loss_sum} + (s3_full ? {1'b0, s3_p} : '0);
    loss_sum_next = (loss_add > {1'b0, LOSS_ONE}) ? LOSS_ONE : loss_add[LOSS_W-1:0];

    e_add = {1'b0, energy_sum} + (ENERGY_W + 1)'(term);
    energy_sum_next = e_add[ENERGY_W] ? {ENERGY_W{1'b1}} : e_add[ENERGY_W-1:0];
  end

  // accumulators, cleared when the frame is handed to the divider
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      queue_sum  <= '0;
      loss_sum   <= '0;
      energy_sum <= '0;
    end else if (s3_valid) begin
      queue_sum  <= queue_sum_next;
      loss_sum   <= loss_sum_next;
      energy_sum <= energy_sum_next;
    end
  end

  // restoring divider step, dividend shifts out of the quotient register
  always_comb begin
    rem_sh   = {rem, quo[DIVD_W-1]};
    rem_diff = rem_sh - {1'b0, denom};
    fits     = (rem_sh >= {1'b0, denom});
  end

  // snapshot, divisor product and division
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      snap_qsum   <= queue_sum;
      snap_loss   <= loss_sum;
      snap_energy <= energy_sum;
    end
    if (cmd.mult) begin
      denom <= DEN_W'(arrival_rate) * DEN_W'(LOSS_ONE - snap_loss);
      rem   <= '0;
      quo   <= {snap_qsum, {FRAC_W{1'b0}}};
      step  <= '0;
    end else if (cmd.div_step) begin
      rem  <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo  <= {quo[DIVD_W-2:0], fits};
      step <= step + STEP_W'(1);
    end
  end

  // response time with saturation
  always_comb begin
    dz = (denom == '0);
    if (dz || (|quo[DIVD_W-1:RT_W])) begin
      rt = {RT_W{1'b1}};
    end else begin
      rt = quo[RT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.publish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.publish) begin
      out_mean   <= snap_qsum[MEANQ_W-1:0];
      out_loss   <= snap_loss;
      out_energy <= snap_energy;
      out_rt     <= rt;
      out_dz     <= dz;
    end
  end

  assign m_tdata = {1'b0, out_rt, out_energy, out_loss, out_mean};
  assign m_tuser = out_dz;

  // status to the controller
  assign status.last_xfer  = in_xfer && s_tlast;
  assign status.pipe_empty = !(s1_valid || s2_valid || s3_valid);
  assign status.div_last   = (step == STEP_W'(DIV_STEPS - 1));
  assign status.out_free   = !m_tvalid || m_tready;

endmodule

FILE: hdl/queue_reward_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_reward_accumulator
// Accumulates mean queue, loss probability and mean energy over the states
// of a Markov chain and reports them with the mean response time.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one chain state per transfer; s_tlast marks the final state.
//   Within a frame a state is taken every cycle. The product pipeline is
//   three stages deep, so after the s_tlast transfer the block drains the
//   pipeline, forms the divisor and runs a one-bit-per-cycle restoring
//   divider over 56 quotient bits. s_tready stays low from the s_tlast
//   transfer on and comes back when the result is placed in the output
//   register.
//   The result waits in that register while m_tready is low; the next frame
//   is accumulated meanwhile, and only its own hand-off waits for the
//   register to free up.
//   cfg_* writes register cfg_index with cfg_data and is always ready;
//   write only while no frame is in progress.
//   Reset clears the sums, the pipeline and the output valid, sets all
//   thresholds and powers to zero and the arrival rate to one.
// ----------------------------------------------------------------------------
module queue_reward_accumulator
  import qra_pkg::*;
#(
  parameter int SERVERS = SERVERS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // input states
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // queue_length[7:0], state_probability[39:8]
  input  logic                  s_tlast,   // last_state
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // results
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // mean_queue[38:0], loss_probability[70:39],
                                           // mean_energy[118:71], response_time[166:119]
  output logic                  m_tuser    // divide_by_zero
);

  localparam int LOSS_LSB = MEANQ_W;
  localparam int RT_LSB   = MEANQ_W + LOSS_W + ENERGY_W;

  qra_cmd_t    cmd;
  qra_status_t status;

  // frame sequencer
  qra_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // arithmetic and registers
  qra_datapath #(
    .SERVERS (SERVERS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  assign s_tready  = cmd.accept;
  assign cfg_ready = 1'b1;

  // the frame end closes the input until the result is handed off
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input accepted right after frame end");

  // a flagged result carries a saturated response time
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[RT_LSB +: RT_W] == {RT_W{1'b1}}))
    else $error("divide_by_zero without saturated response time");

  // loss probability never exceeds one
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[LOSS_LSB +: LOSS_W] <= LOSS_ONE))
    else $error("loss probability above one");

endmodule
